// ===== sv/e2rm_pkg.sv =====
// package for the euler angle to rotation matrix block
// holds payload structs, fixed point constants and the cordic arctangent table
`timescale 1ns / 1ps
package e2rm_pkg;

  localparam int AngleWidth   = 16;
  localparam int ElementWidth = 16;
  localparam int CordicStages = 14;
  localparam int Frac         = 30;
  // q.30 values up to about 2*pi and cordic growth fit in 34 bits
  localparam int QW           = 34;

  localparam logic signed [QW-1:0] QPi      = 34'sd3373259426;
  localparam logic signed [QW-1:0] QHalfPi  = 34'sd1686629713;
  localparam logic signed [QW-1:0] QTwoPi   = 34'sd6746518852;
  localparam logic signed [QW-1:0] CordicK  = 34'sd652032874;

  typedef struct packed {
    logic signed [AngleWidth-1:0] roll_angle;
    logic signed [AngleWidth-1:0] pitch_angle;
    logic signed [AngleWidth-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [ElementWidth-1:0] r00;
    logic signed [ElementWidth-1:0] r01;
    logic signed [ElementWidth-1:0] r02;
    logic signed [ElementWidth-1:0] r10;
    logic signed [ElementWidth-1:0] r11;
    logic signed [ElementWidth-1:0] r12;
    logic signed [ElementWidth-1:0] r20;
    logic signed [ElementWidth-1:0] r21;
    logic signed [ElementWidth-1:0] r22;
  } matrix_t;

  // sine and cosine in q.30
  typedef struct packed {
    logic signed [QW-1:0] s;
    logic signed [QW-1:0] c;
  } sincos_t;

  function automatic logic signed [QW-1:0] atan_q30(input int i);
    logic signed [QW-1:0] r;
    begin
      unique case (i)
        0:  r = 34'sd843314857;
        1:  r = 34'sd497837829;
        2:  r = 34'sd263043837;
        3:  r = 34'sd133525159;
        4:  r = 34'sd67021687;
        5:  r = 34'sd33543516;
        6:  r = 34'sd16775851;
        7:  r = 34'sd8388437;
        8:  r = 34'sd4194283;
        9:  r = 34'sd2097149;
        default: r = QW'(64'sd1 <<< (Frac - i));
      endcase
      return r;
    end
  endfunction

  // q.30 product rounded half up
  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    begin
      p = (2*QW)'(a) * (2*QW)'(b) + (2*QW)'(64'sd1 <<< (Frac - 1));
      return QW'(p >>> Frac);
    end
  endfunction

  // round q.30 to element format and saturate to plus or minus one
  function automatic logic signed [ElementWidth-1:0] to_elem(
      input logic signed [QW-1:0] v);
    localparam int Sh = Frac - (ElementWidth - 2);
    logic signed [QW:0] r;
    logic signed [QW:0] one;
    begin
      one = (QW+1)'(64'sd1 <<< (ElementWidth - 2));
      r = ((QW+1)'(v) + (QW+1)'(64'sd1 <<< (Sh - 1))) >>> Sh;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return ElementWidth'(r);
    end
  endfunction

endpackage

// ===== sv/e2rm_cordic.sv =====
// pipelined cordic: one angle to its sine and cosine in q.30
// uses e2rm_pkg; stage 0 range reduction, then one register per rotation
`timescale 1ns / 1ps
module e2rm_cordic (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [e2rm_pkg::AngleWidth-1:0] angle_i,
  output e2rm_pkg::sincos_t                     sc_o
);
  localparam int N  = e2rm_pkg::CordicStages;
  localparam int QW = e2rm_pkg::QW;

  logic signed [QW-1:0] x_q [N+1];
  logic signed [QW-1:0] y_q [N+1];
  logic signed [QW-1:0] z_q [N+1];
  logic                 flip_q [N+1];

  logic signed [QW-1:0] a_d;
  logic signed [QW-1:0] z_d;
  logic                 flip_d;

  // scale into q.30 and fold into half pi range
  always_comb begin
    a_d = QW'(angle_i) <<< (e2rm_pkg::Frac - (e2rm_pkg::AngleWidth - 3));
    if (a_d > e2rm_pkg::QPi) a_d = a_d - e2rm_pkg::QTwoPi;
    else if (a_d < -e2rm_pkg::QPi) a_d = a_d + e2rm_pkg::QTwoPi;
    flip_d = 1'b0;
    z_d = a_d;
    if (a_d > e2rm_pkg::QHalfPi) begin
      z_d = a_d - e2rm_pkg::QPi;
      flip_d = 1'b1;
    end else if (a_d < -e2rm_pkg::QHalfPi) begin
      z_d = a_d + e2rm_pkg::QPi;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= e2rm_pkg::CordicK;
      y_q[0] <= '0;
      z_q[0] <= z_d;
      flip_q[0] <= flip_d;
    end
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - e2rm_pkg::atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + e2rm_pkg::atan_q30(i);
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign sc_o.s = flip_q[N] ? -y_q[N] : y_q[N];
  assign sc_o.c = flip_q[N] ? -x_q[N] : x_q[N];
endmodule

// ===== sv/euler_to_rotation_matrix_top.sv =====
// channel | valid      | stall      | payload
// in      | in_valid_i | in_stall_o | in_data_i  (e2rm_pkg::angles_t)
// out     | out_valid_o| out_stall_i| out_data_o (e2rm_pkg::matrix_t)
// one transaction per cycle while not stalled; registers in order:
// range fold, cordic rotations, two product stages, sum and round stage
// a stalled result freezes the whole pipeline; in_stall_o is high exactly then
// reset clears only the valid bits
// uses e2rm_pkg and e2rm_cordic
`timescale 1ns / 1ps
module euler_to_rotation_matrix_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  e2rm_pkg::angles_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output e2rm_pkg::matrix_t   out_data_o
);
  localparam int N   = e2rm_pkg::CordicStages;
  localparam int Lat = N + 4;
  localparam int QW  = e2rm_pkg::QW;

  logic en;
  logic [Lat-1:0] vld_q;
  e2rm_pkg::sincos_t rs, ps, ys;

  // whole pipe advances unless the held result is stalled
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  e2rm_cordic u_roll  (.clk_i, .en_i(en), .angle_i(in_data_i.roll_angle),  .sc_o(rs));
  e2rm_cordic u_pitch (.clk_i, .en_i(en), .angle_i(in_data_i.pitch_angle), .sc_o(ps));
  e2rm_cordic u_yaw   (.clk_i, .en_i(en), .angle_i(in_data_i.yaw_angle),   .sc_o(ys));

  // first products
  logic signed [QW-1:0] srsp_q, crsp_q, cpcy_q, cpsy_q, srcp_q, crcp_q;
  logic signed [QW-1:0] crsy_q, srsy_q, crcy_q, srcy_q, sp_q, cy_q, sy_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      srsp_q <= e2rm_pkg::qmul(rs.s, ps.s);
      crsp_q <= e2rm_pkg::qmul(rs.c, ps.s);
      cpcy_q <= e2rm_pkg::qmul(ps.c, ys.c);
      cpsy_q <= e2rm_pkg::qmul(ps.c, ys.s);
      srcp_q <= e2rm_pkg::qmul(rs.s, ps.c);
      crcp_q <= e2rm_pkg::qmul(rs.c, ps.c);
      crsy_q <= e2rm_pkg::qmul(rs.c, ys.s);
      srsy_q <= e2rm_pkg::qmul(rs.s, ys.s);
      crcy_q <= e2rm_pkg::qmul(rs.c, ys.c);
      srcy_q <= e2rm_pkg::qmul(rs.s, ys.c);
      sp_q   <= ps.s;
      cy_q   <= ys.c;
      sy_q   <= ys.s;
    end
  end

  // triple products
  logic signed [QW-1:0] a_q, b_q, c_q, d_q;
  logic signed [QW-1:0] crsy2_q, srsy2_q, crcy2_q, srcy2_q;
  logic signed [QW-1:0] cpcy2_q, cpsy2_q, srcp2_q, crcp2_q, sp2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= e2rm_pkg::qmul(srsp_q, cy_q);
      b_q <= e2rm_pkg::qmul(crsp_q, cy_q);
      c_q <= e2rm_pkg::qmul(srsp_q, sy_q);
      d_q <= e2rm_pkg::qmul(crsp_q, sy_q);
      crsy2_q <= crsy_q;
      srsy2_q <= srsy_q;
      crcy2_q <= crcy_q;
      srcy2_q <= srcy_q;
      cpcy2_q <= cpcy_q;
      cpsy2_q <= cpsy_q;
      srcp2_q <= srcp_q;
      crcp2_q <= crcp_q;
      sp2_q   <= sp_q;
    end
  end

  // sums, rounding and saturation
  e2rm_pkg::matrix_t res_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.r00 <= e2rm_pkg::to_elem(cpcy2_q);
      res_q.r01 <= e2rm_pkg::to_elem(a_q - crsy2_q);
      res_q.r02 <= e2rm_pkg::to_elem(b_q + srsy2_q);
      res_q.r10 <= e2rm_pkg::to_elem(cpsy2_q);
      res_q.r11 <= e2rm_pkg::to_elem(c_q + crcy2_q);
      res_q.r12 <= e2rm_pkg::to_elem(d_q - srcy2_q);
      res_q.r20 <= e2rm_pkg::to_elem(-sp2_q);
      res_q.r21 <= e2rm_pkg::to_elem(srcp2_q);
      res_q.r22 <= e2rm_pkg::to_elem(crcp2_q);
    end
  end

  assign out_valid_o = vld_q[Lat-1];
  assign out_data_o  = res_q;
endmodule

// ===== sv/e2rm_checker.sv =====
// port level checks for the euler angle to rotation matrix block
// uses e2rm_pkg; bound to euler_to_rotation_matrix_top
`timescale 1ns / 1ps
module e2rm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input e2rm_pkg::matrix_t out_data_o
);
  localparam logic signed [e2rm_pkg::ElementWidth-1:0] One =
    e2rm_pkg::ElementWidth'(1 << (e2rm_pkg::ElementWidth - 2));

  // held result stays put while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input is stalled exactly when the output is stalled with a result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall mismatch");

  // saturation bound on elements r00 and r20
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.r20 <= One && out_data_o.r20 >= -One &&
                    out_data_o.r00 <= One && out_data_o.r00 >= -One)
    else $error("element beyond one");
endmodule

bind euler_to_rotation_matrix_top e2rm_checker u_chk (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

// ===== tb/sv/euler_to_rotation_matrix_top_tb.sv =====
// testbench for euler_to_rotation_matrix_top: directed angle table, then random angles
// results are checked against a behavioral cordic predictor; depends on e2rm_pkg
`timescale 1ns / 1ps
module euler_to_rotation_matrix_top_tb;

  localparam int  Latency   = e2rm_pkg::CordicStages + 4;
  localparam int  NumRandom = 530;

  // fixed point constants in q.30, 64 bit
  localparam longint PiQ     = 64'sd3373259426;
  localparam longint HalfPiQ = 64'sd1686629713;
  localparam longint TwoPiQ  = 64'sd6746518852;
  localparam longint GainQ   = 64'sd652032874;

  typedef struct {
    e2rm_pkg::angles_t ang;
    bit                has_exp;
    e2rm_pkg::matrix_t exp_mat;
  } angle_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  e2rm_pkg::angles_t in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  e2rm_pkg::matrix_t out_data_o;

  e2rm_pkg::matrix_t pending_mats[$];
  angle_row_t        angle_table[$];
  int                mismatch_cnt = 0;
  int                matrix_cnt = 0;
  int                sender_idle_pct = 0;
  int                receiver_idle_pct = 0;

  euler_to_rotation_matrix_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock generation
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout with %0d matrices still pending", pending_mats.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return shr_floor(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint atan_entry(int i);
    longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tab[i];
    return 64'sd1 <<< (30 - i);
  endfunction

  // sine and cosine of a q3.13 angle via fixed-length cordic
  task automatic angle_sincos(input logic signed [15:0] raw, output longint s,
                              output longint c);
    longint a, x, y, z, xs, ys;
    bit     flip;
    a = longint'(raw) * (64'sd1 <<< 17);
    flip = 1'b0;
    if (a > PiQ) a -= TwoPiQ;
    else if (a < -PiQ) a += TwoPiQ;
    if (a > HalfPiQ) begin
      a -= PiQ;
      flip = 1'b1;
    end else if (a < -HalfPiQ) begin
      a += PiQ;
      flip = 1'b1;
    end
    x = GainQ;
    y = 0;
    z = a;
    for (int i = 0; i < e2rm_pkg::CordicStages; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z -= atan_entry(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z += atan_entry(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic logic signed [15:0] round_elem(longint v);
    longint r;
    r = shr_floor(v + (64'sd1 <<< 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  // rotation matrix predictor
  task automatic predict_matrix(input e2rm_pkg::angles_t ang, output e2rm_pkg::matrix_t m);
    longint sr, cr, sp, cp, sy, cy, srsp, crsp;
    angle_sincos(ang.roll_angle, sr, cr);
    angle_sincos(ang.pitch_angle, sp, cp);
    angle_sincos(ang.yaw_angle, sy, cy);
    srsp = mul_q30(sr, sp);
    crsp = mul_q30(cr, sp);
    m.r00 = round_elem(mul_q30(cp, cy));
    m.r01 = round_elem(mul_q30(srsp, cy) - mul_q30(cr, sy));
    m.r02 = round_elem(mul_q30(crsp, cy) + mul_q30(sr, sy));
    m.r10 = round_elem(mul_q30(cp, sy));
    m.r11 = round_elem(mul_q30(srsp, sy) + mul_q30(cr, cy));
    m.r12 = round_elem(mul_q30(crsp, sy) - mul_q30(sr, cy));
    m.r20 = round_elem(-sp);
    m.r21 = round_elem(mul_q30(sr, cp));
    m.r22 = round_elem(mul_q30(cr, cp));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("mismatch in matrix %0d: %s got %0d expected %0d", matrix_cnt, what, got,
             want);
  endtask

  // send one angle transaction, holding it while stalled
  task automatic send_angles(input e2rm_pkg::angles_t ang, input bit has_exp,
                             input e2rm_pkg::matrix_t m);
    e2rm_pkg::matrix_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ang;
    if (has_exp) want = m;
    else predict_matrix(ang, want);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_mats.insert(pending_mats.size(), want);
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    e2rm_pkg::matrix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_mats.size() == 0) begin
        report_mismatch("unexpected matrix", 0, 0);
      end else begin
        want = pending_mats.pop_front();
        if (out_data_o.r00 !== want.r00) report_mismatch("r00", out_data_o.r00, want.r00);
        if (out_data_o.r01 !== want.r01) report_mismatch("r01", out_data_o.r01, want.r01);
        if (out_data_o.r02 !== want.r02) report_mismatch("r02", out_data_o.r02, want.r02);
        if (out_data_o.r10 !== want.r10) report_mismatch("r10", out_data_o.r10, want.r10);
        if (out_data_o.r11 !== want.r11) report_mismatch("r11", out_data_o.r11, want.r11);
        if (out_data_o.r12 !== want.r12) report_mismatch("r12", out_data_o.r12, want.r12);
        if (out_data_o.r20 !== want.r20) report_mismatch("r20", out_data_o.r20, want.r20);
        if (out_data_o.r21 !== want.r21) report_mismatch("r21", out_data_o.r21, want.r21);
        if (out_data_o.r22 !== want.r22) report_mismatch("r22", out_data_o.r22, want.r22);
      end
      matrix_cnt++;
    end
  end

  function automatic logic signed [15:0] rand_angle();
    int pick;
    pick = $urandom_range(99);
    // mostly within pi, some raw patterns up to +-4 rad, some near the fold points
    if (pick < 70) return 16'($signed($urandom_range(2 * 25736)) - 25736);
    if (pick < 85) return 16'($urandom);
    return 16'($signed($urandom_range(40)) - 20 +
               (($urandom_range(1)) ? 12868 : -12868) * (($urandom_range(1)) ? 1 : 2));
  endfunction

  function automatic angle_row_t mk_row(int r, int p, int y, bit has_exp = 0,
                                        e2rm_pkg::matrix_t m = '0);
    angle_row_t row;
    row.ang.roll_angle  = 16'(r);
    row.ang.pitch_angle = 16'(p);
    row.ang.yaw_angle   = 16'(y);
    row.has_exp = has_exp;
    row.exp_mat = m;
    return row;
  endfunction

  // append one row to the directed table
  function automatic void add_row(angle_row_t row);
    angle_table.insert(angle_table.size(), row);
  endfunction

  initial begin
    e2rm_pkg::angles_t ang;
    e2rm_pkg::matrix_t zero_mat;
    int                phase_len;
    // all angles zero: the cordic leaves a residual sine of one lsb
    zero_mat = '{r00: 16384, r01: -1, r02: 1, r10: 1, r11: 16384, r12: -1,
                 r20: -1, r21: 1, r22: 16384};

    // directed angle table: zero, pi and half pi, fold points, raw extremes
    add_row(mk_row(0, 0, 0));
    add_row(mk_row(25736, 0, 0));
    add_row(mk_row(-25736, 0, 0));
    add_row(mk_row(0, 25736, 0));
    add_row(mk_row(0, -25736, 0));
    add_row(mk_row(0, 0, 25736));
    add_row(mk_row(0, 0, -25736));
    add_row(mk_row(12868, 12868, 12868));
    add_row(mk_row(-12868, -12868, -12868));
    add_row(mk_row(12869, -12869, 12867));
    add_row(mk_row(32767, -32768, 32767));
    add_row(mk_row(-32768, 32767, -32768));
    add_row(mk_row(25737, -25737, 30000));
    add_row(mk_row(1, -1, 2));
    add_row(mk_row(16'h5555, 16'haaaa, 16'h00ff));
    add_row(mk_row(16'haaaa, 16'h5555, 16'hff00));
    add_row(mk_row(6434, 6434, 6434));
    add_row(mk_row(-19302, 19302, 8578));
    add_row(mk_row(0, 0, 0, 1, zero_mat));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 9;
    receiver_idle_pct = 58;
    foreach (angle_table[k])
      send_angles(angle_table[k].ang, angle_table[k].has_exp, angle_table[k].exp_mat);

    // random angles in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct   = (ph == 0) ? 9 : (ph == 1) ? 58 : 0;
      receiver_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 9 : 0;
      phase_len = NumRandom / 3;
      for (int n = 0; n < phase_len; n++) begin
        ang.roll_angle  = rand_angle();
        ang.pitch_angle = rand_angle();
        ang.yaw_angle   = rand_angle();
        send_angles(ang, 1'b0, zero_mat);
      end
    end
    in_valid_i <= 1'b0;

    // drain
    for (int w = 0; w < 100000 && pending_mats.size() != 0; w++) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (pending_mats.size() != 0) report_mismatch("matrices left over", pending_mats.size(), 0);

    $display("checked %0d rotation matrices from directed and random angle triples",
             matrix_cnt);
    $display("angles covered fold points, +-pi limits and raw 16 bit extremes");
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
